### rtl/wtrm_pkg.sv
// wtrm_pkg: shared types, widths, constants and helpers of the windowed traffic rate meter
// no dependencies; imported by every rtl module of the block
package wtrm_pkg;

	localparam int DEFAULT_MAX_WINDOW = 16;

	localparam int WIN_CFG_W  = 5;
	localparam int DEV_W      = 8;
	localparam int CNT_W      = 48;
	localparam int RATE_W     = 58;
	localparam int PM_W       = 16;
	localparam int PNUM_W     = RATE_W + 1;
	localparam int SCALE_W    = 10;
	localparam int PROD_W     = PNUM_W + SCALE_W;
	localparam int DEN_W      = CNT_W + 1;
	localparam int NUM_W      = RATE_W;
	localparam int STEP_W     = 6;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = CNT_W;

	localparam logic [STEP_W-1:0]    RATE_STEPS = STEP_W'(RATE_W);
	localparam logic [STEP_W-1:0]    PM_STEPS   = STEP_W'(PM_W);
	localparam logic [PM_W-1:0]      PM_SAT     = '1;
	localparam logic [WIN_CFG_W-1:0] WIN_RESET  = WIN_CFG_W'(3);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WINDOW  = 2'd0,
		REG_MAX_IN  = 2'd1,
		REG_MAX_OUT = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [DEV_W-1:0] device_id;
		logic [CNT_W-1:0] in_bytes;
		logic [CNT_W-1:0] out_bytes;
		logic [CNT_W-1:0] time_ms;
	} in_item_t;

	typedef struct packed {
		logic [RATE_W-1:0] in_rate;
		logic [RATE_W-1:0] out_rate;
		logic [PM_W-1:0]   in_permille;
		logic [PM_W-1:0]   out_permille;
		logic [PM_W-1:0]   total_permille;
	} out_item_t;

	typedef struct packed {
		logic [WIN_CFG_W-1:0] window_samples;
		logic [CNT_W-1:0]     max_in_rate;
		logic [CNT_W-1:0]     max_out_rate;
	} cfg_t;

	typedef struct packed {
		logic              start;
		logic [DEN_W-1:0]  rem_init;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
		logic [STEP_W-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DROP,
		ST_WRITE,
		ST_CHECK,
		ST_RATE_MUL,
		ST_RATE_DIV,
		ST_RATE_WAIT,
		ST_PM_LOAD,
		ST_PM_MUL,
		ST_PM_TEST,
		ST_PM_WAIT,
		ST_OUT
	} state_t;

	typedef enum logic {
		RATE_IN,
		RATE_OUT
	} rate_sel_t;

	typedef enum logic [1:0] {
		PM_IN,
		PM_OUT,
		PM_TOT
	} pm_sel_t;

	// x * 1000 as 1024x - 32x + 8x
	function automatic logic [PROD_W-1:0] mul_scale(input logic [PNUM_W-1:0] x);
		logic [PROD_W-1:0] xe;
		xe = PROD_W'(x);
		return (xe << 10) - (xe << 5) + (xe << 3);
	endfunction

endpackage

### rtl/wtrm_ring.sv
// wtrm_ring: sample ring memory, one write port and one registered read port
// depends on wtrm_pkg for the sample type
module wtrm_ring #(
	parameter int DEPTH = wtrm_pkg::DEFAULT_MAX_WINDOW
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wtrm_pkg::in_item_t       wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output wtrm_pkg::in_item_t       rd_data
);
	import wtrm_pkg::*;

	in_item_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

### rtl/wtrm_div.sv
// wtrm_div: shared restoring divider, one quotient bit per cycle
// depends on wtrm_pkg for the request and response structs
module wtrm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  wtrm_pkg::div_req_t req,
	output wtrm_pkg::div_rsp_t rsp
);
	import wtrm_pkg::*;

	logic [STEP_W-1:0] cnt_q;
	logic              done_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [NUM_W-1:0]  num_q;
	logic [NUM_W-1:0]  quot_q;

	logic [DEN_W:0] trial;
	logic [DEN_W:0] diff;
	logic           qbit;

	// shift in the next numerator bit, subtract when it fits
	assign trial = {rem_q, num_q[NUM_W-1]};
	assign diff  = trial - {1'b0, den_q};
	assign qbit  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				cnt_q <= req.steps;
			end else if (cnt_q != '0) begin
				cnt_q  <= cnt_q - STEP_W'(1);
				done_q <= cnt_q == STEP_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem_init;
			den_q  <= req.den;
			num_q  <= req.num;
			quot_q <= '0;
		end else if (cnt_q != '0) begin
			rem_q  <= qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
			num_q  <= {num_q[NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[NUM_W-2:0], qbit};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

### rtl/wtrm_seq.sv
// wtrm_seq: sequencer and datapath; ring pointers, window checks, rate and permille steps
// depends on wtrm_pkg; drives wtrm_ring and wtrm_div
module wtrm_seq #(
	parameter int MAX_WINDOW = wtrm_pkg::DEFAULT_MAX_WINDOW
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  wtrm_pkg::cfg_t                cfg,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  wtrm_pkg::in_item_t            in_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output wtrm_pkg::out_item_t           out_data,
	output logic                          ring_we,
	output logic [$clog2(MAX_WINDOW)-1:0] ring_waddr,
	output wtrm_pkg::in_item_t            ring_wdata,
	output logic                          ring_re,
	output logic [$clog2(MAX_WINDOW)-1:0] ring_raddr,
	input  wtrm_pkg::in_item_t            ring_rdata,
	output wtrm_pkg::div_req_t            div_req,
	input  wtrm_pkg::div_rsp_t            div_rsp
);
	import wtrm_pkg::*;

	localparam int IW   = $clog2(MAX_WINDOW);
	localparam int SW   = $clog2(MAX_WINDOW + 1);
	localparam int SUMW = IW + 1;
	localparam int CW   = (SW > WIN_CFG_W) ? SW : WIN_CFG_W;
	localparam int HIW  = PROD_W - PM_W;

	function automatic logic [IW-1:0] wrap(input logic [SUMW-1:0] s);
		if (s >= SUMW'(MAX_WINDOW)) begin
			return IW'(s - SUMW'(MAX_WINDOW));
		end
		return IW'(s);
	endfunction

	state_t state_q, state_d;

	logic [IW-1:0] oldest_q;
	logic [SW-1:0] stored_q;
	rate_sel_t     rsel_q;
	pm_sel_t       psel_q;
	logic          out_valid_q;

	in_item_t          smp_q;
	logic              in_ok_q, out_ok_q;
	logic [CNT_W-1:0]  din_q, dout_q, dt_q;
	logic [PROD_W-1:0] mul_q;
	logic [RATE_W-1:0] rin_q, rout_q;
	logic [PNUM_W-1:0] pnum_q;
	logic [DEN_W-1:0]  pden_q;
	logic [PM_W-1:0]   pin_q, pout_q, ptot_q;
	out_item_t         out_data_q;

	logic [CW-1:0] ws_ext;
	logic [SW-1:0] win_eff;
	logic          accept, out_free;
	logic          base_ok, rate_ok;
	logic          pm_zero, pm_sat, pm_div;
	logic          rate_last, pm_last;

	assign ws_ext = CW'(cfg.window_samples);

	always_comb begin
		if (ws_ext == '0) begin
			win_eff = SW'(1);
		end else if (ws_ext > CW'(MAX_WINDOW)) begin
			win_eff = SW'(MAX_WINDOW);
		end else begin
			win_eff = SW'(ws_ext);
		end
	end

	assign accept    = in_valid && (state_q == ST_IDLE);
	assign out_free  = !out_valid_q || out_ready;
	assign rate_last = rsel_q == RATE_OUT;
	assign pm_last   = psel_q == PM_TOT;

	// ring read data is the oldest stored sample
	assign base_ok = (stored_q >= SW'(2)) && (ring_rdata.device_id == smp_q.device_id)
		&& (smp_q.time_ms > ring_rdata.time_ms);
	assign rate_ok = (rsel_q == RATE_IN) ? in_ok_q : out_ok_q;

	assign pm_zero = pden_q == '0;
	// quotient reaches 2^16 exactly when the product over 2^16 is at least the divisor
	assign pm_sat  = mul_q[PROD_W-1:PM_W] >= HIW'(pden_q);
	assign pm_div  = !pm_zero && !pm_sat;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (in_valid) state_d = ST_DROP;
			ST_DROP:      state_d = ST_WRITE;
			ST_WRITE:     state_d = ST_CHECK;
			ST_CHECK:     state_d = ST_RATE_MUL;
			ST_RATE_MUL:  state_d = ST_RATE_DIV;
			ST_RATE_DIV: begin
				if (rate_ok) begin
					state_d = ST_RATE_WAIT;
				end else begin
					state_d = rate_last ? ST_PM_LOAD : ST_RATE_MUL;
				end
			end
			ST_RATE_WAIT: begin
				if (div_rsp.done) begin
					state_d = rate_last ? ST_PM_LOAD : ST_RATE_MUL;
				end
			end
			ST_PM_LOAD:   state_d = ST_PM_MUL;
			ST_PM_MUL:    state_d = ST_PM_TEST;
			ST_PM_TEST: begin
				if (pm_div) begin
					state_d = ST_PM_WAIT;
				end else begin
					state_d = pm_last ? ST_OUT : ST_PM_LOAD;
				end
			end
			ST_PM_WAIT: begin
				if (div_rsp.done) begin
					state_d = pm_last ? ST_OUT : ST_PM_LOAD;
				end
			end
			ST_OUT:       if (out_free) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		in_ready     = state_q == ST_IDLE;
		ring_we      = state_q == ST_WRITE;
		ring_re      = state_q == ST_WRITE;
		ring_waddr   = wrap(SUMW'(oldest_q) + SUMW'(stored_q));
		ring_raddr   = oldest_q;
		ring_wdata   = smp_q;
		div_req.start = ((state_q == ST_RATE_DIV) && rate_ok)
			|| ((state_q == ST_PM_TEST) && pm_div);
		if (state_q == ST_PM_TEST) begin
			div_req.rem_init = mul_q[PM_W+DEN_W-1:PM_W];
			div_req.num      = {mul_q[PM_W-1:0], {(NUM_W-PM_W){1'b0}}};
			div_req.den      = pden_q;
			div_req.steps    = PM_STEPS;
		end else begin
			div_req.rem_init = '0;
			div_req.num      = mul_q[NUM_W-1:0];
			div_req.den      = DEN_W'(dt_q);
			div_req.steps    = RATE_STEPS;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			oldest_q    <= '0;
			stored_q    <= '0;
			rsel_q      <= RATE_IN;
			psel_q      <= PM_IN;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				rsel_q <= RATE_IN;
				psel_q <= PM_IN;
			end
			// drop the oldest entries until the new sample fits the window
			if (state_q == ST_DROP && stored_q >= win_eff) begin
				oldest_q <= wrap(SUMW'(oldest_q) + SUMW'(stored_q - win_eff + SW'(1)));
				stored_q <= win_eff - SW'(1);
			end
			if (state_q == ST_WRITE) begin
				stored_q <= stored_q + SW'(1);
			end
			if ((state_q == ST_RATE_DIV && !rate_ok)
				|| (state_q == ST_RATE_WAIT && div_rsp.done)) begin
				rsel_q <= RATE_OUT;
			end
			if ((state_q == ST_PM_TEST && !pm_div)
				|| (state_q == ST_PM_WAIT && div_rsp.done)) begin
				unique case (psel_q)
					PM_IN:   psel_q <= PM_OUT;
					PM_OUT:  psel_q <= PM_TOT;
					default: psel_q <= PM_TOT;
				endcase
			end
			if (state_q == ST_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			smp_q <= in_data;
		end
		if (state_q == ST_CHECK) begin
			in_ok_q  <= base_ok && (smp_q.in_bytes >= ring_rdata.in_bytes);
			out_ok_q <= base_ok && (smp_q.out_bytes >= ring_rdata.out_bytes);
			din_q    <= smp_q.in_bytes - ring_rdata.in_bytes;
			dout_q   <= smp_q.out_bytes - ring_rdata.out_bytes;
			dt_q     <= smp_q.time_ms - ring_rdata.time_ms;
		end
		if (state_q == ST_RATE_MUL) begin
			mul_q <= mul_scale(PNUM_W'((rsel_q == RATE_IN) ? din_q : dout_q));
		end
		if (state_q == ST_PM_MUL) begin
			mul_q <= mul_scale(pnum_q);
		end
		if (state_q == ST_RATE_DIV && !rate_ok) begin
			if (rsel_q == RATE_IN) begin
				rin_q <= '0;
			end else begin
				rout_q <= '0;
			end
		end
		if (state_q == ST_RATE_WAIT && div_rsp.done) begin
			if (rsel_q == RATE_IN) begin
				rin_q <= div_rsp.quot[RATE_W-1:0];
			end else begin
				rout_q <= div_rsp.quot[RATE_W-1:0];
			end
		end
		if (state_q == ST_PM_LOAD) begin
			unique case (psel_q)
				PM_IN: begin
					pnum_q <= PNUM_W'(rin_q);
					pden_q <= DEN_W'(cfg.max_in_rate);
				end
				PM_OUT: begin
					pnum_q <= PNUM_W'(rout_q);
					pden_q <= DEN_W'(cfg.max_out_rate);
				end
				default: begin
					pnum_q <= PNUM_W'(rin_q) + PNUM_W'(rout_q);
					pden_q <= DEN_W'(cfg.max_in_rate) + DEN_W'(cfg.max_out_rate);
				end
			endcase
		end
		if ((state_q == ST_PM_TEST && !pm_div) || (state_q == ST_PM_WAIT && div_rsp.done)) begin
			logic [PM_W-1:0] pm_val;
			pm_val = (state_q == ST_PM_WAIT) ? div_rsp.quot[PM_W-1:0]
				: (pm_zero ? '0 : PM_SAT);
			unique case (psel_q)
				PM_IN:   pin_q  <= pm_val;
				PM_OUT:  pout_q <= pm_val;
				default: ptot_q <= pm_val;
			endcase
		end
		if (state_q == ST_OUT && out_free) begin
			out_data_q.in_rate        <= rin_q;
			out_data_q.out_rate       <= rout_q;
			out_data_q.in_permille    <= pin_q;
			out_data_q.out_permille   <= pout_q;
			out_data_q.total_permille <= ptot_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

### rtl/windowed_traffic_rate_meter_top.sv
// Windowed traffic rate meter. Each sample transaction (device id, received and sent byte
// counters, millisecond timestamp) is stored in a ring of MAX_WINDOW entries after the oldest
// entries are dropped so that fewer than window_samples remain; one result transaction then
// reports receive and send rates in bytes per second between the oldest and newest stored
// samples, and receive, send and combined load in permille of max_in_rate, max_out_rate and
// their sum, saturating at 65535. A rate is 0 with fewer than two samples, a device change,
// a falling counter or no elapsed time; a permille is 0 when its maximum is 0. The single
// shared restoring divider takes 58 steps for each rate quotient that is needed and 16 for
// each permille that neither saturates nor has a zero maximum; in_ready is low while a
// sample is in work, and the finished result waits in the output register while the next
// sample is taken. Configuration writes through cfg_we take effect on the next edge and
// belong to idle periods. The ring has no reset or clearing pass.
// depends on wtrm_pkg, wtrm_ring, wtrm_div and wtrm_seq
module windowed_traffic_rate_meter_top #(
	parameter int MAX_WINDOW = wtrm_pkg::DEFAULT_MAX_WINDOW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [wtrm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wtrm_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  wtrm_pkg::in_item_t                  in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output wtrm_pkg::out_item_t                 out_data
);
	import wtrm_pkg::*;

	localparam int IW = $clog2(MAX_WINDOW);

	cfg_t cfg_q;

	logic          ring_we, ring_re;
	logic [IW-1:0] ring_waddr, ring_raddr;
	in_item_t      ring_wdata, ring_rdata;
	div_req_t      div_req;
	div_rsp_t      div_rsp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_samples <= WIN_RESET;
			cfg_q.max_in_rate    <= '0;
			cfg_q.max_out_rate   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WINDOW:  cfg_q.window_samples <= cfg_data[WIN_CFG_W-1:0];
				REG_MAX_IN:  cfg_q.max_in_rate    <= cfg_data[CNT_W-1:0];
				REG_MAX_OUT: cfg_q.max_out_rate   <= cfg_data[CNT_W-1:0];
				default:     ;
			endcase
		end
	end

	wtrm_seq #(
		.MAX_WINDOW(MAX_WINDOW)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.ring_we    (ring_we),
		.ring_waddr (ring_waddr),
		.ring_wdata (ring_wdata),
		.ring_re    (ring_re),
		.ring_raddr (ring_raddr),
		.ring_rdata (ring_rdata),
		.div_req    (div_req),
		.div_rsp    (div_rsp)
	);

	wtrm_ring #(
		.DEPTH(MAX_WINDOW)
	) u_ring (
		.clk     (clk),
		.wr_en   (ring_we),
		.wr_addr (ring_waddr),
		.wr_data (ring_wdata),
		.rd_en   (ring_re),
		.rd_addr (ring_raddr),
		.rd_data (ring_rdata)
	);

	wtrm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

endmodule

### rtl/wtrm_checker.sv
// wtrm_checker: port-level assertions for the windowed traffic rate meter
// depends on wtrm_pkg; bound to windowed_traffic_rate_meter_top below
module wtrm_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input wtrm_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input wtrm_pkg::out_item_t out_data
);
	import wtrm_pkg::*;

	// an offered sample holds until it is taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("sample changed or dropped while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed or dropped while stalled");

	// one sample at a time: the sequencer drops ready after an accepted transaction
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input ready right after an accepted transaction");

	// a zero receive rate gives a zero receive load
	a_in_pm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_rate == '0 |-> out_data.in_permille == '0)
		else $error("nonzero receive permille with zero receive rate");

	// both rates zero gives a zero combined load
	a_tot_pm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.in_rate == '0 && out_data.out_rate == '0
		|-> out_data.total_permille == '0)
		else $error("nonzero combined permille with zero rates");

endmodule

bind windowed_traffic_rate_meter_top wtrm_checker u_wtrm_checker (.*);

### tb/sv/windowed_traffic_rate_meter_top_tb.sv
// testbench for windowed_traffic_rate_meter_top: directed and random counter samples, with a
// scoreboard class that predicts rates and permille loads from its own copy of the sample ring
// depends on wtrm_pkg and the rtl of windowed_traffic_rate_meter_top
`timescale 1ns / 100ps

module windowed_traffic_rate_meter_top_tb;
	import wtrm_pkg::*;

	localparam logic [CNT_W-1:0] CNT_MAX    = '1;
	localparam int               RING_DEPTH = DEFAULT_MAX_WINDOW;
	localparam int               DRAIN_WAIT = 200;
	localparam int               LONG_HOLD  = 3000;
	localparam int               PHASES     = 8;
	localparam int               PHASE_LEN  = 225;

	class rate_meter_scoreboard;
		out_item_t         pending[$];
		logic [DEV_W-1:0]  dev_ring[RING_DEPTH];
		logic [CNT_W-1:0]  rx_ring[RING_DEPTH];
		logic [CNT_W-1:0]  tx_ring[RING_DEPTH];
		logic [CNT_W-1:0]  stamp_ring[RING_DEPTH];
		int unsigned       oldest;
		int unsigned       stored;
		logic [WIN_CFG_W-1:0] window;
		logic [CNT_W-1:0]  full_in;
		logic [CNT_W-1:0]  full_out;
		int unsigned       samples;
		int unsigned       results;
		int unsigned       errors;
		int unsigned       zero_windows;
		int unsigned       saturated;

		function new();
			oldest = 0;
			stored = 0;
			window = WIN_RESET;
			full_in = '0;
			full_out = '0;
			samples = 0;
			results = 0;
			errors = 0;
			zero_windows = 0;
			saturated = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_WINDOW: window = value[WIN_CFG_W-1:0];
				REG_MAX_IN: full_in = value;
				REG_MAX_OUT: full_out = value;
				default: ;
			endcase
		endfunction

		// bytes per second between the oldest and newest stored samples of one counter
		function logic [RATE_W-1:0] window_rate(rate_sel_t which, int unsigned first,
				int unsigned last);
			logic [63:0] c_old;
			logic [63:0] c_new;
			logic [63:0] q;
			c_old = (which == RATE_IN) ? rx_ring[first] : tx_ring[first];
			c_new = (which == RATE_IN) ? rx_ring[last] : tx_ring[last];
			if (stored < 2)
				return '0;
			if (dev_ring[last] != dev_ring[first])
				return '0;
			if (c_new < c_old)
				return '0;
			if (stamp_ring[last] <= stamp_ring[first])
				return '0;
			q = ((c_new - c_old) * 64'd1000) / (64'(stamp_ring[last]) - 64'(stamp_ring[first]));
			return q[RATE_W-1:0];
		endfunction

		function logic [PM_W-1:0] load_permille(logic [63:0] num, logic [63:0] den);
			logic [63:0] q;
			logic [63:0] r;
			logic [63:0] v;
			if (den == 0)
				return '0;
			q = num / den;
			r = num % den;
			if (q >= 66)
				return PM_SAT;
			v = q * 1000 + (r * 1000) / den;
			return (v > 64'(PM_SAT)) ? PM_SAT : v[PM_W-1:0];
		endfunction

		function void note_sample(in_item_t s);
			int unsigned win;
			int unsigned slot;
			int unsigned last;
			out_item_t   want;
			win = window;
			if (win < 1)
				win = 1;
			if (win > RING_DEPTH)
				win = RING_DEPTH;
			while (stored >= win) begin
				oldest = (oldest + 1) % RING_DEPTH;
				stored--;
			end
			slot = (oldest + stored) % RING_DEPTH;
			dev_ring[slot] = s.device_id;
			rx_ring[slot] = s.in_bytes;
			tx_ring[slot] = s.out_bytes;
			stamp_ring[slot] = s.time_ms;
			stored++;
			last = (oldest + stored - 1) % RING_DEPTH;
			want.in_rate = window_rate(RATE_IN, oldest, last);
			want.out_rate = window_rate(RATE_OUT, oldest, last);
			want.in_permille = load_permille(64'(want.in_rate), 64'(full_in));
			want.out_permille = load_permille(64'(want.out_rate), 64'(full_out));
			want.total_permille = load_permille(64'(want.in_rate) + 64'(want.out_rate),
				64'(full_in) + 64'(full_out));
			if (stored >= 2 && want.in_rate == '0 && want.out_rate == '0)
				zero_windows++;
			if (want.total_permille == PM_SAT)
				saturated++;
			samples++;
			pending.push_back(want);
		endfunction

		task report(string what, logic [63:0] got, logic [63:0] want);
			errors++;
			// keep the log short when something is badly broken
			if (errors <= 60)
				$display("mismatch: %s on result %0d, got %0d expected %0d",
					what, results, got, want);
		endtask

		task check_result(out_item_t got);
			out_item_t want;
			results++;
			if (pending.size() == 0) begin
				report("result with no sample waiting", 64'(got.in_rate), 0);
			end else begin
				want = pending.pop_front();
				if (got.in_rate !== want.in_rate)
					report("in_rate", 64'(got.in_rate), 64'(want.in_rate));
				if (got.out_rate !== want.out_rate)
					report("out_rate", 64'(got.out_rate), 64'(want.out_rate));
				if (got.in_permille !== want.in_permille)
					report("in_permille", 64'(got.in_permille), 64'(want.in_permille));
				if (got.out_permille !== want.out_permille)
					report("out_permille", 64'(got.out_permille), 64'(want.out_permille));
				if (got.total_permille !== want.total_permille)
					report("total_permille", 64'(got.total_permille),
						64'(want.total_permille));
			end
		endtask
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	in_item_t              in_data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_item_t             out_data;

	rate_meter_scoreboard sb;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	bit          hold_req = 1'b0;
	int unsigned hold_left = 0;
	int unsigned settings_used = 0;

	// running counter stream that random samples follow
	logic [DEV_W-1:0] cur_dev = '0;
	logic [CNT_W-1:0] cur_rx = '0;
	logic [CNT_W-1:0] cur_tx = '0;
	logic [CNT_W-1:0] cur_stamp = '0;

	windowed_traffic_rate_meter_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#30_000_000;
		$display("status: fail");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(out_data);
	end

	function automatic logic [CNT_W-1:0] rand48();
		logic [63:0] w;
		w = {$urandom, $urandom};
		return w[CNT_W-1:0];
	endfunction

	function automatic in_item_t sample_of(logic [DEV_W-1:0] dev, logic [CNT_W-1:0] rx,
			logic [CNT_W-1:0] tx, logic [CNT_W-1:0] stamp);
		in_item_t s;
		s.device_id = dev;
		s.in_bytes = rx;
		s.out_bytes = tx;
		s.time_ms = stamp;
		return s;
	endfunction

	function automatic logic [CNT_W-1:0] pick_full_scale();
		case ($urandom_range(4))
			0: return '0;
			1: return CNT_W'($urandom_range(1, 1000));
			2: return CNT_W'($urandom_range(1000, 5_000_000));
			3: return rand48();
			default: return CNT_MAX;
		endcase
	endfunction

	// mostly a steadily advancing counter stream, with resets, stalled clocks,
	// device switches and plain noise mixed in
	function automatic in_item_t next_sample();
		int unsigned      r;
		logic [CNT_W-1:0] dt;
		r = $urandom_range(99);
		if (r >= 95)
			return sample_of(DEV_W'($urandom), rand48(), rand48(), rand48());
		if ($urandom_range(3) != 0)
			dt = CNT_W'($urandom_range(1, 3000));
		else
			dt = (rand48() >> $urandom_range(4, 47)) + CNT_W'(1);
		cur_rx = cur_rx + (rand48() >> $urandom_range(0, 47));
		cur_tx = cur_tx + (rand48() >> $urandom_range(0, 47));
		if (r < 78) begin
			cur_stamp = cur_stamp + dt;
		end else if (r < 84) begin
			if ($urandom_range(1))
				cur_rx = rand48() >> $urandom_range(0, 47);
			else
				cur_tx = rand48() >> $urandom_range(0, 47);
			cur_stamp = cur_stamp + dt;
		end else if (r < 90) begin
			if ($urandom_range(1))
				cur_stamp = cur_stamp - CNT_W'($urandom_range(1, 5000));
		end else begin
			cur_dev = DEV_W'($urandom);
			cur_stamp = cur_stamp + dt;
		end
		return sample_of(cur_dev, cur_rx, cur_tx, cur_stamp);
	endfunction

	task automatic configure(logic [WIN_CFG_W-1:0] win, logic [CNT_W-1:0] full_in,
			logic [CNT_W-1:0] full_out);
		cfg_we <= 1'b1;
		cfg_index <= REG_WINDOW;
		cfg_data <= CFG_DATA_W'(win);
		@(posedge clk);
		sb.write_reg(REG_WINDOW, CFG_DATA_W'(win));
		cfg_index <= REG_MAX_IN;
		cfg_data <= full_in;
		@(posedge clk);
		sb.write_reg(REG_MAX_IN, full_in);
		cfg_index <= REG_MAX_OUT;
		cfg_data <= full_out;
		@(posedge clk);
		sb.write_reg(REG_MAX_OUT, full_out);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic send_sample(in_item_t s);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= s;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sb.note_sample(s);
	endtask

	// lower valid and wait for every outstanding result
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic [WIN_CFG_W-1:0] win;
		sb = new();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 26;
		recv_idle_pct = 54;

		// window of two: first sample, extremes, falling counters, stalled and reversed
		// clock, device changes
		configure(5'd2, 48'd1, '0);
		send_sample(sample_of(8'd0, '0, '0, '0));
		send_sample(sample_of(8'd0, CNT_MAX, CNT_MAX, 48'd1));
		send_sample(sample_of(8'd0, '0, CNT_MAX, 48'd2));
		send_sample(sample_of(8'd0, 48'd5, 48'd100, 48'd2));
		send_sample(sample_of(8'd0, 48'd10, 48'd200, 48'd1));
		send_sample(sample_of(8'd1, 48'd20, 48'd300, 48'd1000));
		send_sample(sample_of(8'd255, CNT_MAX, CNT_MAX, CNT_MAX));
		send_sample(sample_of(8'd255, CNT_MAX, CNT_MAX, CNT_MAX));
		drain();

		// zero window acts as one sample: rates stay zero
		configure(5'd0, CNT_MAX, CNT_MAX);
		send_sample(sample_of(8'd3, CNT_MAX, '0, 48'd5));
		send_sample(sample_of(8'd7, '0, '0, '0));
		drain();

		// oversized window acts as the full ring; permille right at and past saturation
		configure(5'd31, 48'd1000, 48'd1000);
		for (int k = 1; k <= 16; k++)
			send_sample(sample_of(8'd7, CNT_W'(65535 * k), CNT_W'(65536 * k),
				CNT_W'(1000 * k)));
		drain();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: win = 5'd3;
				1: win = 5'd16;
				2: win = 5'd1;
				3: win = 5'd5;
				4: win = WIN_CFG_W'($urandom_range(17, 31));
				5: win = 5'd0;
				6: win = WIN_CFG_W'($urandom_range(2, 15));
				default: win = 5'd2;
			endcase
			if (p == PHASES - 1)
				configure(win, '0, '0);
			else
				configure(win, pick_full_scale(), pick_full_scale());
			if (p == 3) begin
				send_idle_pct = 54;
				recv_idle_pct = 26;
			end else if (p == 6) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			// long receiver hold-off while samples keep coming
			if (p == 1)
				hold_req = 1'b1;
			for (int n = 0; n < PHASE_LEN; n++)
				send_sample(next_sample());
			drain();
		end

		repeat (DRAIN_WAIT) @(posedge clk);
		$display("covered %0d samples and %0d checked results over %0d register settings",
			sb.samples, sb.results, settings_used);
		$display("windows with both rates zero: %0d, saturated total load: %0d, mismatches: %0d",
			sb.zero_windows, sb.saturated, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
